### rtl/wcfe_pkg.sv
// Shared constants and types for the wheel command frame encoder.
package wcfe_pkg;

	localparam int FRAME_BYTES = 13;
	localparam int WHEELS      = 4;
	localparam int POS_W       = 4;

	typedef logic        [7:0]  byte_t;
	typedef logic        [2:0]  id_t;
	typedef logic signed [15:0] speed_t;
	typedef logic        [14:0] mag_t;
	typedef logic        [18:0] quot_t;
	typedef logic        [11:0] scaled_t;
	typedef logic        [POS_W-1:0] pos_t;

	localparam id_t     ID_MAX_DIRECT = 3'd5;
	localparam id_t     ID_OVERFLOW   = 3'd7;
	localparam mag_t    SPEED_LIMIT   = 15'd21760;
	localparam scaled_t SCALE_MAX     = 12'd4095;
	localparam int      RECIP_SHIFT   = 27;
	localparam logic [20:0] RECIP_85  = 21'd1579033;
	localparam pos_t    LAST_POS      = POS_W'(FRAME_BYTES - 1);

	localparam logic       HDR_FLAG = 1'b1;
	localparam logic [1:0] HI_MARK  = 2'b10;
	localparam logic [1:0] LO_MARK  = 2'b11;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

### rtl/wcfe_cmd_if.sv
// Drive command channel: valid, ready and one command word.
interface wcfe_cmd_if;
	import wcfe_pkg::*;

	logic   valid;
	logic   ready;
	id_t    robot_id;
	logic   spinner_on;
	logic   kick_on;
	speed_t speed_one;
	speed_t speed_two;
	speed_t speed_three;
	speed_t speed_four;

	modport source (
		output valid, robot_id, spinner_on, kick_on,
		output speed_one, speed_two, speed_three, speed_four,
		input  ready
	);
	modport sink (
		input  valid, robot_id, spinner_on, kick_on,
		input  speed_one, speed_two, speed_three, speed_four,
		output ready
	);
endinterface

### rtl/wcfe_byte_if.sv
// Frame byte channel: valid, ready and one frame byte word.
interface wcfe_byte_if;
	import wcfe_pkg::*;

	logic  valid;
	logic  ready;
	byte_t frame_byte;
	pos_t  byte_position;
	logic  last_byte;

	modport source (
		output valid, frame_byte, byte_position, last_byte,
		input  ready
	);
	modport sink (
		input  valid, frame_byte, byte_position, last_byte,
		output ready
	);
endinterface

### rtl/wheel_command_frame_encoder.sv
// Top level: command pipeline, four speed lanes and the frame byte serializer.
// The command word passes stages s1 to s4 and is then loaded into the serializer.
// Throughput: one frame byte per cycle while frame.ready is high. Commands are
// accepted while a frame is being sent; up to four wait in the pipeline stages.
// Reset: arst_n clears the stage valid bits and the serializer; data
// registers are not reset.
module wheel_command_frame_encoder (
	input  logic              clk,
	input  logic              arst_n,
	wcfe_cmd_if.sink          cmd,
	wcfe_byte_if.source       frame
);
	import wcfe_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic ser_free, load, byte_take, last_c;
	stage_en_t lane_en;

	id_t    id_s1;
	logic   spin_s1, kick_s1;
	speed_t speed_s1 [WHEELS];
	id_t    idc_s2, idc_s3, idc_s4;
	logic   spin_s2, spin_s3, spin_s4;
	logic   kick_s2, kick_s3, kick_s4;
	logic    pos_s4 [WHEELS];
	scaled_t mag_s4 [WHEELS];

	byte_t frame_d [FRAME_BYTES];
	byte_t frame_q [FRAME_BYTES];
	pos_t  pos_q;
	logic  busy_q;

	assign last_c    = (pos_q == LAST_POS);
	assign byte_take = frame.valid && frame.ready;
	assign ser_free  = !busy_q || (frame.ready && last_c);
	assign load      = v_s4 && ser_free;
	assign en4       = !v_s4 || ser_free;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign cmd.ready = en1;

	assign lane_en.s2 = en2;
	assign lane_en.s3 = en3;
	assign lane_en.s4 = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cmd.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			id_s1       <= cmd.robot_id;
			spin_s1     <= cmd.spinner_on;
			kick_s1     <= cmd.kick_on;
			speed_s1[0] <= cmd.speed_one;
			speed_s1[1] <= cmd.speed_two;
			speed_s1[2] <= cmd.speed_three;
			speed_s1[3] <= cmd.speed_four;
		end
		if (en2) begin
			idc_s2  <= (id_s1 > ID_MAX_DIRECT) ? ID_OVERFLOW : id_s1;
			spin_s2 <= spin_s1;
			kick_s2 <= kick_s1;
		end
		if (en3) begin
			idc_s3  <= idc_s2;
			spin_s3 <= spin_s2;
			kick_s3 <= kick_s2;
		end
		if (en4) begin
			idc_s4  <= idc_s3;
			spin_s4 <= spin_s3;
			kick_s4 <= kick_s3;
		end
	end

	for (genvar w = 0; w < WHEELS; w++) begin : g_lane
		wcfe_speed_lane u_lane (
			.clk      (clk),
			.en       (lane_en),
			.speed_s1 (speed_s1[w]),
			.pos_s4   (pos_s4[w]),
			.mag_s4   (mag_s4[w])
		);
		assign frame_d[1 + 3*w] = {1'b0, idc_s4, HDR_FLAG, 2'(w), pos_s4[w]};
		assign frame_d[2 + 3*w] = {HI_MARK, mag_s4[w][11:6]};
		assign frame_d[3 + 3*w] = {LO_MARK, mag_s4[w][5:0]};
	end

	assign frame_d[0] = {1'b0, idc_s4, 2'b00, spin_s4, kick_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (byte_take) begin
			pos_q <= pos_q + 1'b1;
			if (last_c) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame_d;
		end else if (byte_take) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				frame_q[i] <= frame_q[i + 1];
			end
		end
	end

	assign frame.valid         = busy_q;
	assign frame.frame_byte    = frame_q[0];
	assign frame.byte_position = pos_q;
	assign frame.last_byte     = last_c;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= LAST_POS))
		else $error("byte position beyond frame end");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_take && !last_c) |=> (frame.valid && frame.byte_position == $past(pos_q) + 1'b1))
		else $error("frame broken before last word");

	a_new_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_take && last_c) |=> (!frame.valid || frame.byte_position == '0))
		else $error("frame did not restart at position zero");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && pos_q == '0))
		else $error("load did not start a frame");

	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !ser_free) |=> (v_s4 && $stable(mag_s4[0]) && $stable(idc_s4)))
		else $error("stalled command lost its word");
`endif
endmodule

### rtl/wcfe_speed_lane.sv
// One wheel lane: magnitude and clamp, scale by 4095, divide by 21760.
module wcfe_speed_lane (
	input  logic                clk,
	input  wcfe_pkg::stage_en_t en,
	input  wcfe_pkg::speed_t    speed_s1,
	output logic                pos_s4,
	output wcfe_pkg::scaled_t   mag_s4
);
	import wcfe_pkg::*;

	logic [15:0] abs_c;
	mag_t        clamp_c;
	logic        pos_c;
	logic [26:0] prod_c;
	logic [39:0] recip_c;

	mag_t  mag_s2;
	logic  pos_s2;
	quot_t quot_s3;
	logic  pos_s3;

	assign abs_c   = speed_s1[15] ? (16'(~speed_s1) + 16'd1) : 16'(speed_s1);
	assign clamp_c = (abs_c > 16'(SPEED_LIMIT)) ? SPEED_LIMIT : abs_c[14:0];
	assign pos_c   = !speed_s1[15] && (speed_s1 != '0);

	assign prod_c  = 27'(mag_s2) * 27'(SCALE_MAX);
	assign recip_c = 40'(quot_s3) * 40'(RECIP_85);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_s2 <= clamp_c;
			pos_s2 <= pos_c;
		end
		if (en.s3) begin
			quot_s3 <= prod_c[26:8];
			pos_s3  <= pos_s2;
		end
		if (en.s4) begin
			mag_s4 <= recip_c[RECIP_SHIFT +: 12];
			pos_s4 <= pos_s3;
		end
	end
endmodule
